### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the scheduler datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define TLRQ_ASSERT(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TLRQ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tlrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types, codes and sizes of the two-level ready queue scheduler.
// ----------------------------------------------------------------------------
package tlrq_pkg;

    localparam int MAX_TASKS = 64;
    localparam int TASK_W    = 6;
    localparam int ADDR_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NEXT_W    = TASK_W + 1;
    localparam int ID_LIMIT  = ((MAX_TASKS - 1) < 63) ? (MAX_TASKS - 1) : 63;

    localparam int MODE_W   = 3;
    localparam int TICK_W   = 8;
    localparam int QUANT_W  = 20;
    localparam int MS_W     = 16;
    localparam int SLEEP_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COND_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0]  RST_TICK_MS  = TICK_W'(10);
    localparam logic [QUANT_W-1:0] RST_SHORT_US = QUANT_W'(10000);
    localparam logic [QUANT_W-1:0] RST_LONG_US  = QUANT_W'(20000);

    typedef enum logic [COND_W-1:0] {
        COND_RUNNING    = 3'd0,
        COND_READY      = 3'd1,
        COND_WAITING    = 3'd2,
        COND_TERMINATED = 3'd3,
        COND_DELETED    = 3'd4
    } cond_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_REMOVE  = 3'd1,
        MODE_WAKE    = 3'd2,
        MODE_SUSPEND = 3'd3,
        MODE_EXPIRE  = 3'd4,
        MODE_FINISH  = 3'd5,
        MODE_IDLE    = 3'd6,
        MODE_QUERY   = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_ID      = 2'd1,
        ST_FULL        = 2'd2,
        ST_NOT_WAITING = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_MS  = 2'd0,
        REG_SHORT_US = 2'd1,
        REG_LONG_US  = 2'd2
    } cfg_reg_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        C_NONE,
        C_LATCH,
        C_ADD,
        C_BAD,
        C_RD_ID,
        C_ID_OP,
        C_RD_RUN,
        C_CUR_WR,
        C_WALK_RD,
        C_WALK_WR,
        C_SLP_RD,
        C_SLP_TRD,
        C_SLP_EVAL,
        C_SLP_END,
        C_POP_SEL,
        C_Q_RD,
        C_Q_EVAL,
        C_Q_END,
        C_DISP_RD,
        C_DISP_WR,
        C_FINISH
    } cmd_t;

    typedef struct packed {
        cond_t             cond;
        logic              high;
        logic              long_q;
        logic [MS_W-1:0]   queued;
        logic              woken;
    } row_t;

    typedef struct packed {
        logic [TASK_W-1:0]  task_num;
        logic [SLEEP_W-1:0] ticks;
    } sleeper_t;

    typedef struct packed {
        logic  in_valid;
        mode_t mode;
        logic  id_ok;
        logic  table_full;
        logic  run_set;
        logic  walk_done;
        logic  slp_done;
        logic  q_done;
        logic  any_ready;
        logic  out_free;
    } stat_t;

endpackage

### rtl/tlrq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlrq_cmd_if;
    import tlrq_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [TASK_W-1:0]   task_id;
    logic                high_priority;
    logic                long_quantum;
    logic [SLEEP_W-1:0]  sleep_ticks;

    modport source (output valid, mode, task_id, high_priority, long_quantum,
                    sleep_ticks, input ready);
    modport sink   (input valid, mode, task_id, high_priority, long_quantum,
                    sleep_ticks, output ready);
endinterface

interface tlrq_rsp_if;
    import tlrq_pkg::*;
    logic                valid;
    logic                ready;
    logic [TASK_W-1:0]   result_task;
    logic                dispatched;
    logic [QUANT_W-1:0]  quantum_us;
    logic [STATUS_W-1:0] status;
    logic [COND_W-1:0]   task_condition;
    logic [MS_W-1:0]     queued_ms;

    modport source (output valid, result_task, dispatched, quantum_us, status,
                    task_condition, queued_ms, input ready);
    modport sink   (input valid, result_task, dispatched, quantum_us, status,
                    task_condition, queued_ms, output ready);
endinterface

interface tlrq_cfg_if;
    import tlrq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [QUANT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tlrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/tlrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_ctrl
// Sequencer: walks each request through its datapath micro-operations.
// ----------------------------------------------------------------------------
module tlrq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  tlrq_pkg::stat_t stat,
    output tlrq_pkg::cmd_t  cmd,
    output logic            in_ready
);
    import tlrq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ID_OP, S_CUR, S_WALK_CHK, S_WALK_WR,
        S_SLP_CHK, S_SLP_TRD, S_SLP_EVAL, S_POP_SEL, S_Q_CHK, S_Q_EVAL,
        S_DISP_RD, S_DISP_WR, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = C_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    cmd        = C_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.mode)
                    MODE_ADD:
                    begin
                        cmd        = C_ADD;
                        state_next = S_FINISH;
                    end
                    MODE_REMOVE, MODE_WAKE, MODE_QUERY:
                    begin
                        if (!stat.id_ok)
                        begin
                            cmd        = C_BAD;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd        = C_RD_ID;
                            state_next = S_ID_OP;
                        end
                    end
                    default:
                    begin
                        if (stat.run_set)
                        begin
                            cmd        = C_RD_RUN;
                            state_next = S_CUR;
                        end
                        else
                        begin
                            state_next = S_WALK_CHK;
                        end
                    end
                endcase
            end
            S_ID_OP:
            begin
                cmd        = C_ID_OP;
                state_next = (stat.mode == MODE_REMOVE) ? S_Q_CHK : S_FINISH;
            end
            S_CUR:
            begin
                cmd        = C_CUR_WR;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_SLP_CHK;
                end
                else
                begin
                    cmd        = C_WALK_RD;
                    state_next = S_WALK_WR;
                end
            end
            S_WALK_WR:
            begin
                cmd        = C_WALK_WR;
                state_next = S_WALK_CHK;
            end
            S_SLP_CHK:
            begin
                if (stat.slp_done)
                begin
                    cmd        = C_SLP_END;
                    state_next = S_POP_SEL;
                end
                else
                begin
                    cmd        = C_SLP_RD;
                    state_next = S_SLP_TRD;
                end
            end
            S_SLP_TRD:
            begin
                cmd        = C_SLP_TRD;
                state_next = S_SLP_EVAL;
            end
            S_SLP_EVAL:
            begin
                cmd        = C_SLP_EVAL;
                state_next = S_SLP_CHK;
            end
            S_POP_SEL:
            begin
                if (stat.any_ready)
                begin
                    cmd        = C_POP_SEL;
                    state_next = S_Q_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_Q_CHK:
            begin
                if (stat.q_done)
                begin
                    cmd        = C_Q_END;
                    state_next = (stat.mode == MODE_REMOVE) ? S_FINISH : S_DISP_RD;
                end
                else
                begin
                    cmd        = C_Q_RD;
                    state_next = S_Q_EVAL;
                end
            end
            S_Q_EVAL:
            begin
                cmd        = C_Q_EVAL;
                state_next = S_Q_CHK;
            end
            S_DISP_RD:
            begin
                cmd        = C_DISP_RD;
                state_next = S_DISP_WR;
            end
            S_DISP_WR:
            begin
                cmd        = C_DISP_WR;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd        = C_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;
endmodule

### rtl/tlrq_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tlrq_dp
// Datapath: task table, ready FIFOs, sleep list, counters and result regs.
// ----------------------------------------------------------------------------
module tlrq_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  tlrq_pkg::cmd_t  cmd,
    input  logic            in_ready,
    output tlrq_pkg::stat_t stat,
    tlrq_cmd_if.sink        cmd_ch,
    tlrq_rsp_if.source      rsp_ch,
    tlrq_cfg_if.sink        cfg_ch
);
    import tlrq_pkg::*;

    // configuration
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [QUANT_W-1:0] short_reg, short_next;
    logic [QUANT_W-1:0] long_reg, long_next;

    // control state
    logic [CNT_W-1:0]  hcnt_reg, hcnt_next, lcnt_reg, lcnt_next, scnt_reg, scnt_next;
    logic [NEXT_W-1:0] next_reg, next_next;
    logic [TASK_W-1:0] run_reg, run_next;
    logic [NEXT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0]  k_reg, k_next, kept_reg, kept_next;
    logic              qsel_reg, qsel_next, pop_reg, pop_next, found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    mode_t              mode_reg, mode_next;
    logic [TASK_W-1:0]  id_reg, id_next;
    logic               hi_reg, hi_next, lg_reg, lg_next;
    logic [SLEEP_W-1:0] ticks_reg, ticks_next;
    sleeper_t           slp_reg, slp_next;
    logic [TASK_W-1:0]  head_reg, head_next;
    logic [TASK_W-1:0]  res_task_reg, res_task_next, o_task_reg, o_task_next;
    logic               res_disp_reg, res_disp_next, o_disp_reg, o_disp_next;
    logic [QUANT_W-1:0] res_quant_reg, res_quant_next, o_quant_reg, o_quant_next;
    status_t            res_status_reg, res_status_next, o_status_reg, o_status_next;
    cond_t              res_cond_reg, res_cond_next, o_cond_reg, o_cond_next;
    logic [MS_W-1:0]    res_ms_reg, res_ms_next, o_ms_reg, o_ms_next;

    // memories
    logic              t_we, h_we, l_we, s_we;
    logic [ADDR_W-1:0] t_waddr, t_raddr, h_waddr, l_waddr, q_raddr, s_waddr, s_raddr;
    row_t              t_wdata, t_row;
    logic [TASK_W-1:0] q_wdata, h_rdata, l_rdata, q_rd;
    sleeper_t          s_wdata, s_rdata;

    logic              push_en, push_hi;
    logic [TASK_W-1:0] push_id;
    logic [MS_W:0]     ms_sum;
    mode_t             in_mode;

    tlrq_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_TASKS)) u_task_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_row)
    );
    tlrq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_high_ram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(h_rdata)
    );
    tlrq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_low_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(l_rdata)
    );
    tlrq_ram #(.WIDTH($bits(sleeper_t)), .DEPTH(MAX_TASKS)) u_sleep_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    assign in_mode = mode_t'(cmd_ch.mode);
    assign q_rd    = qsel_reg ? h_rdata : l_rdata;
    assign ms_sum  = {1'b0, t_row.queued} + (MS_W+1)'(tick_reg);

    always_comb
    begin
        tick_next = tick_reg;  short_next = short_reg;  long_next = long_reg;
        hcnt_next = hcnt_reg;  lcnt_next = lcnt_reg;  scnt_next = scnt_reg;
        next_next = next_reg;  run_next = run_reg;  i_next = i_reg;
        k_next = k_reg;  kept_next = kept_reg;
        qsel_next = qsel_reg;  pop_next = pop_reg;  found_next = found_reg;
        out_valid_next = out_valid_reg;
        mode_next = mode_reg;  id_next = id_reg;  hi_next = hi_reg;  lg_next = lg_reg;
        ticks_next = ticks_reg;  slp_next = slp_reg;  head_next = head_reg;
        res_task_next = res_task_reg;  res_disp_next = res_disp_reg;
        res_quant_next = res_quant_reg;  res_status_next = res_status_reg;
        res_cond_next = res_cond_reg;  res_ms_next = res_ms_reg;
        o_task_next = o_task_reg;  o_disp_next = o_disp_reg;  o_quant_next = o_quant_reg;
        o_status_next = o_status_reg;  o_cond_next = o_cond_reg;  o_ms_next = o_ms_reg;

        t_we = 1'b0;  t_waddr = '0;  t_wdata = t_row;  t_raddr = '0;
        h_we = 1'b0;  h_waddr = '0;  l_we = 1'b0;  l_waddr = '0;
        q_wdata = '0;  q_raddr = '0;
        s_we = 1'b0;  s_waddr = '0;  s_wdata = '0;  s_raddr = '0;
        push_en = 1'b0;  push_hi = 1'b0;  push_id = '0;

        case (cmd)
            C_LATCH:
            begin
                mode_next  = in_mode;
                id_next    = cmd_ch.task_id;
                hi_next    = cmd_ch.high_priority;
                lg_next    = cmd_ch.long_quantum;
                ticks_next = cmd_ch.sleep_ticks;
                i_next     = NEXT_W'(1);
                k_next     = '0;
                kept_next  = '0;
                found_next = 1'b0;
                res_task_next = (in_mode inside {MODE_SUSPEND, MODE_EXPIRE, MODE_FINISH,
                                                 MODE_IDLE}) ? '0 : cmd_ch.task_id;
                res_disp_next   = 1'b0;
                res_quant_next  = '0;
                res_status_next = ST_OK;
                res_cond_next   = COND_RUNNING;
                res_ms_next     = '0;
            end
            C_ADD:
            begin
                if (stat.table_full)
                begin
                    res_task_next   = '0;
                    res_status_next = ST_FULL;
                end
                else
                begin
                    t_we    = 1'b1;
                    t_waddr = ADDR_W'(next_reg);
                    t_wdata = '{cond: COND_READY, high: hi_reg, long_q: lg_reg,
                                queued: '0, woken: 1'b0};
                    push_en = 1'b1;
                    push_hi = hi_reg;
                    push_id = TASK_W'(next_reg);
                    next_next     = next_reg + 1'b1;
                    res_task_next = TASK_W'(next_reg);
                end
            end
            C_BAD:
            begin
                res_status_next = ST_BAD_ID;
                if (mode_reg == MODE_QUERY)
                begin
                    res_cond_next = COND_DELETED;
                end
            end
            C_RD_ID:
            begin
                t_raddr = ADDR_W'(id_reg);
            end
            C_ID_OP:
            begin
                case (mode_reg)
                    MODE_REMOVE:
                    begin
                        t_we    = 1'b1;
                        t_waddr = ADDR_W'(id_reg);
                        t_wdata.cond   = COND_DELETED;
                        t_wdata.queued = '0;
                        qsel_next = t_row.high;
                        pop_next  = 1'b0;
                    end
                    MODE_WAKE:
                    begin
                        if (t_row.cond != COND_WAITING)
                        begin
                            res_status_next = ST_NOT_WAITING;
                        end
                        else
                        begin
                            t_we    = 1'b1;
                            t_waddr = ADDR_W'(id_reg);
                            t_wdata.cond  = COND_READY;
                            t_wdata.woken = 1'b1;
                            push_en = 1'b1;
                            push_hi = t_row.high;
                            push_id = id_reg;
                        end
                    end
                    MODE_QUERY:
                    begin
                        res_cond_next = t_row.cond;
                        res_ms_next   = t_row.queued;
                    end
                    default:
                    begin
                    end
                endcase
            end
            C_RD_RUN:
            begin
                t_raddr = ADDR_W'(run_reg);
            end
            C_CUR_WR:
            begin
                if (t_row.cond == COND_RUNNING)
                begin
                    t_we    = 1'b1;
                    t_waddr = ADDR_W'(run_reg);
                    case (mode_reg)
                        MODE_SUSPEND:
                        begin
                            t_wdata.cond = COND_WAITING;
                            if (scnt_reg < CNT_W'(MAX_TASKS))
                            begin
                                s_we      = 1'b1;
                                s_waddr   = ADDR_W'(scnt_reg);
                                s_wdata   = '{task_num: run_reg, ticks: ticks_reg};
                                scnt_next = scnt_reg + 1'b1;
                            end
                        end
                        MODE_EXPIRE:
                        begin
                            t_wdata.cond = COND_READY;
                            push_en = 1'b1;
                            push_hi = t_row.high;
                            push_id = run_reg;
                        end
                        default:
                        begin
                            t_wdata.cond = COND_TERMINATED;
                        end
                    endcase
                end
            end
            C_WALK_RD:
            begin
                t_raddr = ADDR_W'(i_reg);
            end
            C_WALK_WR:
            begin
                if (t_row.cond == COND_READY)
                begin
                    t_we    = 1'b1;
                    t_waddr = ADDR_W'(i_reg);
                    t_wdata.queued = ms_sum[MS_W] ? '1 : ms_sum[MS_W-1:0];
                end
                i_next = i_reg + 1'b1;
            end
            C_SLP_RD:
            begin
                s_raddr = ADDR_W'(k_reg);
            end
            C_SLP_TRD:
            begin
                slp_next = s_rdata;
                t_raddr  = ADDR_W'(s_rdata.task_num);
            end
            C_SLP_EVAL:
            begin
                if (t_row.woken)
                begin
                    t_we    = 1'b1;
                    t_waddr = ADDR_W'(slp_reg.task_num);
                    t_wdata.woken = 1'b0;
                end
                else if (slp_reg.ticks <= SLEEP_W'(1))
                begin
                    if (t_row.cond == COND_WAITING)
                    begin
                        t_we    = 1'b1;
                        t_waddr = ADDR_W'(slp_reg.task_num);
                        t_wdata.cond = COND_READY;
                        push_en = 1'b1;
                        push_hi = t_row.high;
                        push_id = slp_reg.task_num;
                    end
                end
                else
                begin
                    s_we      = 1'b1;
                    s_waddr   = ADDR_W'(kept_reg);
                    s_wdata   = '{task_num: slp_reg.task_num, ticks: slp_reg.ticks - 1'b1};
                    kept_next = kept_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
            end
            C_SLP_END:
            begin
                scnt_next = kept_reg;
                run_next  = '0;
            end
            C_POP_SEL:
            begin
                qsel_next  = (hcnt_reg != '0);
                pop_next   = 1'b1;
                k_next     = '0;
                kept_next  = '0;
                found_next = 1'b0;
            end
            C_Q_RD:
            begin
                q_raddr = ADDR_W'(k_reg);
            end
            C_Q_EVAL:
            begin
                if (found_reg)
                begin
                    // close the gap left by the matched entry
                    q_wdata = q_rd;
                    h_we    = qsel_reg;
                    l_we    = !qsel_reg;
                    h_waddr = ADDR_W'(k_reg - 1'b1);
                    l_waddr = ADDR_W'(k_reg - 1'b1);
                end
                else if (pop_reg ? (k_reg == '0) : (q_rd == id_reg))
                begin
                    found_next = 1'b1;
                    head_next  = q_rd;
                end
                k_next = k_reg + 1'b1;
            end
            C_Q_END:
            begin
                if (found_reg)
                begin
                    if (qsel_reg)
                    begin
                        hcnt_next = hcnt_reg - 1'b1;
                    end
                    else
                    begin
                        lcnt_next = lcnt_reg - 1'b1;
                    end
                end
            end
            C_DISP_RD:
            begin
                t_raddr = ADDR_W'(head_reg);
            end
            C_DISP_WR:
            begin
                t_we    = 1'b1;
                t_waddr = ADDR_W'(head_reg);
                t_wdata.cond   = COND_RUNNING;
                run_next       = head_reg;
                res_task_next  = head_reg;
                res_disp_next  = 1'b1;
                res_quant_next = t_row.long_q ? long_reg : short_reg;
            end
            C_FINISH:
            begin
                o_task_next   = res_task_reg;
                o_disp_next   = res_disp_reg;
                o_quant_next  = res_quant_reg;
                o_status_next = res_status_reg;
                o_cond_next   = res_cond_reg;
                o_ms_next     = res_ms_reg;
            end
            default:
            begin
            end
        endcase

        if (push_en)
        begin
            q_wdata = push_id;
            if (push_hi)
            begin
                if (hcnt_reg < CNT_W'(MAX_TASKS))
                begin
                    h_we      = 1'b1;
                    h_waddr   = ADDR_W'(hcnt_reg);
                    hcnt_next = hcnt_reg + 1'b1;
                end
            end
            else if (lcnt_reg < CNT_W'(MAX_TASKS))
            begin
                l_we      = 1'b1;
                l_waddr   = ADDR_W'(lcnt_reg);
                lcnt_next = lcnt_reg + 1'b1;
            end
        end

        if (rsp_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd == C_FINISH)
        begin
            out_valid_next = 1'b1;
        end

        if (cfg_ch.valid)
        begin
            case (cfg_reg_t'(cfg_ch.index))
                REG_TICK_MS:  tick_next  = cfg_ch.data[TICK_W-1:0];
                REG_SHORT_US: short_next = cfg_ch.data;
                REG_LONG_US:  long_next  = cfg_ch.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= RST_TICK_MS;
            short_reg     <= RST_SHORT_US;
            long_reg      <= RST_LONG_US;
            hcnt_reg      <= '0;
            lcnt_reg      <= '0;
            scnt_reg      <= '0;
            next_reg      <= NEXT_W'(1);
            run_reg       <= '0;
            i_reg         <= NEXT_W'(1);
            k_reg         <= '0;
            kept_reg      <= '0;
            qsel_reg      <= 1'b0;
            pop_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            short_reg     <= short_next;
            long_reg      <= long_next;
            hcnt_reg      <= hcnt_next;
            lcnt_reg      <= lcnt_next;
            scnt_reg      <= scnt_next;
            next_reg      <= next_next;
            run_reg       <= run_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            kept_reg      <= kept_next;
            qsel_reg      <= qsel_next;
            pop_reg       <= pop_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        hi_reg         <= hi_next;
        lg_reg         <= lg_next;
        ticks_reg      <= ticks_next;
        slp_reg        <= slp_next;
        head_reg       <= head_next;
        res_task_reg   <= res_task_next;
        res_disp_reg   <= res_disp_next;
        res_quant_reg  <= res_quant_next;
        res_status_reg <= res_status_next;
        res_cond_reg   <= res_cond_next;
        res_ms_reg     <= res_ms_next;
        o_task_reg     <= o_task_next;
        o_disp_reg     <= o_disp_next;
        o_quant_reg    <= o_quant_next;
        o_status_reg   <= o_status_next;
        o_cond_reg     <= o_cond_next;
        o_ms_reg       <= o_ms_next;
    end

    assign stat.in_valid   = cmd_ch.valid;
    assign stat.mode       = mode_reg;
    assign stat.id_ok      = (id_reg != '0) && ({1'b0, id_reg} < next_reg);
    assign stat.table_full = (next_reg > NEXT_W'(ID_LIMIT));
    assign stat.run_set    = (run_reg != '0);
    assign stat.walk_done  = (i_reg >= next_reg);
    assign stat.slp_done   = (k_reg == scnt_reg);
    assign stat.q_done     = (k_reg == (qsel_reg ? hcnt_reg : lcnt_reg));
    assign stat.any_ready  = (hcnt_reg != '0) || (lcnt_reg != '0);
    assign stat.out_free   = !out_valid_reg || rsp_ch.ready;

    assign cmd_ch.ready          = in_ready;
    assign cfg_ch.ready          = 1'b1;
    assign rsp_ch.valid          = out_valid_reg;
    assign rsp_ch.result_task    = o_task_reg;
    assign rsp_ch.dispatched     = o_disp_reg;
    assign rsp_ch.quantum_us     = o_quant_reg;
    assign rsp_ch.status         = o_status_reg;
    assign rsp_ch.task_condition = o_cond_reg;
    assign rsp_ch.queued_ms      = o_ms_reg;

    `TLRQ_ASSERT(a_cnt_bound, clk, rst_n, (hcnt_reg <= CNT_W'(MAX_TASKS)) && (lcnt_reg <= CNT_W'(MAX_TASKS)) && (scnt_reg <= CNT_W'(MAX_TASKS)), "queue count past depth")
    `TLRQ_ASSERT(a_kept_behind, clk, rst_n, kept_reg <= k_reg, "sleep compaction overtook scan")
    `TLRQ_ASSERT(a_run_known, clk, rst_n, (run_reg == '0) || ({1'b0, run_reg} < next_reg), "running task never allocated")
    `TLRQ_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd == C_FINISH, out_valid_reg, "finished request not presented")
endmodule

### rtl/two_level_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_ready_queue_scheduler
// Task scheduler with high/low ready FIFOs and a timed sleep list.
// ----------------------------------------------------------------------------
// One request at a time. Add and bad-number requests finish after decode,
// wake and query after one task table read; remove also searches the FIFO
// of its task entry by entry. A scheduling pass (suspend, quantum expiry,
// finish, idle tick) updates the running task, walks every allocated task,
// then the sleep list, and dispatches the head of the high FIFO, else of the
// low one, if either holds a task; the task table RAM's single read port sets
// the walk rate. The response sits in an output register, so the block is
// ready for the next request while it waits, once the previous one is taken.
// Register writes (index 0 tick_ms, 1 short_quantum_us, 2 long_quantum_us)
// are always ready and must only be issued while the block is idle.
module two_level_ready_queue_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    tlrq_cmd_if.sink   cmd,
    tlrq_rsp_if.source rsp,
    tlrq_cfg_if.sink   cfg
);
    import tlrq_pkg::*;

    cmd_t  dp_cmd;   // micro-op for this cycle
    stat_t dp_stat;  // datapath flags back to the sequencer
    logic  in_ready;

    // Sequencer: decode, table walk, sleep walk, FIFO pop, dispatch.
    tlrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (dp_stat),
        .cmd      (dp_cmd),
        .in_ready (in_ready)
    );

    // Task table, FIFOs and sleep list live in RAMs inside the datapath.
    tlrq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd_ch   (cmd),
        .rsp_ch   (rsp),
        .cfg_ch   (cfg)
    );
endmodule

### tb/sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sched_checker
// Watches the request, response and register write channels of the
// scheduler, keeps its own copy of the task table, ready FIFOs and sleep
// list, predicts one response per accepted request and compares it.
// ----------------------------------------------------------------------------
module sched_checker
    import tlrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tlrq_cmd_if        cmd,
    tlrq_rsp_if        rsp,
    tlrq_cfg_if        cfg,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [TASK_W-1:0]   result_task;
        logic                dispatched;
        logic [QUANT_W-1:0]  quantum_us;
        logic [STATUS_W-1:0] status;
        logic [COND_W-1:0]   task_condition;
        logic [MS_W-1:0]     queued_ms;
    } reply_t;

    logic [TICK_W-1:0]  tick_ms;
    logic [QUANT_W-1:0] short_us;
    logic [QUANT_W-1:0] long_us;

    cond_t             cond_tbl [MAX_TASKS];
    logic              is_high  [MAX_TASKS];
    logic              is_long  [MAX_TASKS];
    logic [MS_W-1:0]   waited   [MAX_TASKS];
    logic              woken    [MAX_TASKS];
    int                high_q [$];
    int                low_q  [$];
    int                sleeper_id [$];
    int                sleeper_ticks [$];
    int                next_num;
    int                running;
    reply_t            replies [$];

    assign pending = replies.size();

    function automatic bit num_ok(int n);
        return n >= 1 && n < next_num && n <= ID_LIMIT;
    endfunction

    function automatic bit cur_running();
        return num_ok(running) && cond_tbl[running] == COND_RUNNING;
    endfunction

    task automatic enqueue_ready(int n);
        cond_tbl[n] = COND_READY;
        if (is_high[n])
            high_q.push_back(n);
        else
            low_q.push_back(n);
    endtask

    task automatic drop_from(ref int q[$], input int n);
        foreach (q[k])
            if (q[k] == n)
            begin
                q.delete(k);
                return;
            end
    endtask

    task automatic schedule_pass(inout reply_t r);
        int keep_id [$];
        int keep_t [$];
        int v;
        int n;
        n = 0;
        if (cur_running())
            cond_tbl[running] = COND_TERMINATED;
        for (int i = 1; i < next_num && i < MAX_TASKS; i++)
            if (cond_tbl[i] == COND_READY)
            begin
                v = int'(waited[i]) + int'(tick_ms);
                waited[i] = (v > 65535) ? 16'hFFFF : MS_W'(v);
            end
        foreach (sleeper_id[k])
        begin
            if (woken[sleeper_id[k]])
                woken[sleeper_id[k]] = 1'b0;
            else if (sleeper_ticks[k] <= 1)
            begin
                if (cond_tbl[sleeper_id[k]] == COND_WAITING)
                    enqueue_ready(sleeper_id[k]);
            end
            else
            begin
                keep_id.push_back(sleeper_id[k]);
                keep_t.push_back(sleeper_ticks[k] - 1);
            end
        end
        sleeper_id = keep_id;
        sleeper_ticks = keep_t;
        if (high_q.size() > 0)
            n = high_q.pop_front();
        else if (low_q.size() > 0)
            n = low_q.pop_front();
        running = n;
        if (n != 0)
        begin
            cond_tbl[n] = COND_RUNNING;
            r.result_task = TASK_W'(n);
            r.dispatched = 1'b1;
            r.quantum_us = is_long[n] ? long_us : short_us;
        end
    endtask

    task automatic predict_request(mode_t m, int id, logic hi, logic lg, int ticks);
        reply_t r;
        r = '0;
        r.result_task = TASK_W'(id);
        r.status = ST_OK;
        case (m)
            MODE_ADD:
                if (next_num > ID_LIMIT)
                begin
                    r.result_task = '0;
                    r.status = ST_FULL;
                end
                else
                begin
                    is_high[next_num] = hi;
                    is_long[next_num] = lg;
                    waited[next_num] = '0;
                    woken[next_num] = 1'b0;
                    enqueue_ready(next_num);
                    r.result_task = TASK_W'(next_num);
                    next_num++;
                end
            MODE_REMOVE:
                if (!num_ok(id))
                    r.status = ST_BAD_ID;
                else
                begin
                    if (is_high[id])
                        drop_from(high_q, id);
                    else
                        drop_from(low_q, id);
                    cond_tbl[id] = COND_DELETED;
                    waited[id] = '0;
                end
            MODE_WAKE:
                if (!num_ok(id))
                    r.status = ST_BAD_ID;
                else if (cond_tbl[id] != COND_WAITING)
                    r.status = ST_NOT_WAITING;
                else
                begin
                    woken[id] = 1'b1;
                    enqueue_ready(id);
                end
            MODE_QUERY:
                if (!num_ok(id))
                begin
                    r.status = ST_BAD_ID;
                    r.task_condition = COND_DELETED;
                end
                else
                begin
                    r.task_condition = cond_tbl[id];
                    r.queued_ms = waited[id];
                end
            default:
            begin
                r.result_task = '0;
                if (m == MODE_SUSPEND && cur_running())
                begin
                    cond_tbl[running] = COND_WAITING;
                    if (sleeper_id.size() < MAX_TASKS)
                    begin
                        sleeper_id.push_back(running);
                        sleeper_ticks.push_back(ticks);
                    end
                end
                else if (m == MODE_EXPIRE && cur_running())
                    enqueue_ready(running);
                schedule_pass(r);
            end
        endcase
        replies.push_back(r);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t w;
        if (!rst_n)
        begin
            tick_ms = RST_TICK_MS;
            short_us = RST_SHORT_US;
            long_us = RST_LONG_US;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                cond_tbl[i] = COND_DELETED;
                is_high[i] = 0;
                is_long[i] = 0;
                waited[i] = 0;
                woken[i] = 0;
            end
            high_q.delete();
            low_q.delete();
            sleeper_id.delete();
            sleeper_ticks.delete();
            replies.delete();
            next_num = 1;
            running = 0;
            fail_count = 0;
        end
        else
        begin
            // response first: a request taken this edge cannot answer this edge
            if (rsp.valid && rsp.ready)
            begin
                if (replies.size() == 0)
                begin
                    $display("unexpected response at %0t", $realtime);
                    fail_count++;
                end
                else
                begin
                    w = replies.pop_front();
                    if (rsp.result_task !== w.result_task)
                        report("result_task", rsp.result_task, w.result_task);
                    if (rsp.dispatched !== w.dispatched)
                        report("dispatched", rsp.dispatched, w.dispatched);
                    if (rsp.quantum_us !== w.quantum_us)
                        report("quantum_us", rsp.quantum_us, w.quantum_us);
                    if (rsp.status !== w.status)
                        report("status", rsp.status, w.status);
                    if (rsp.task_condition !== w.task_condition)
                        report("task_condition", rsp.task_condition, w.task_condition);
                    if (rsp.queued_ms !== w.queued_ms)
                        report("queued_ms", rsp.queued_ms, w.queued_ms);
                end
            end
            if (cfg.valid && cfg.ready)
                case (cfg_reg_t'(cfg.index))
                    REG_TICK_MS:  tick_ms = cfg.data[TICK_W-1:0];
                    REG_SHORT_US: short_us = cfg.data;
                    REG_LONG_US:  long_us = cfg.data;
                    default: ;
                endcase
            if (cmd.valid && cmd.ready)
                predict_request(mode_t'(cmd.mode), int'(cmd.task_id), cmd.high_priority,
                                cmd.long_quantum, int'(cmd.sleep_ticks));
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler requests in bursts, register writes between phases and a
// stalling response sink; the checker beside the block judges every response.
// ----------------------------------------------------------------------------
module testbench;
    import tlrq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   gap_left = 0;
    int   burst_left = 0;

    tlrq_cmd_if cmd ();
    tlrq_rsp_if rsp ();
    tlrq_cfg_if cfg ();

    two_level_ready_queue_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    sched_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        cmd.valid = 1'b0;
        cmd.mode = '0;
        cmd.task_id = '0;
        cmd.high_priority = 1'b0;
        cmd.long_quantum = 1'b0;
        cmd.sleep_ticks = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rsp.ready = 1'b0;
    end

    // Response sink: stall phases of random length, some long open stretches.
    initial
    begin
        int run;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(0, 3) == 0 ? $urandom_range(30, 200) : $urandom_range(1, 8);
            repeat (run)
            begin
                @(posedge clk);
                rsp.ready <= 1'b1;
            end
            run = $urandom_range(0, 6);
            repeat (run)
            begin
                @(posedge clk);
                rsp.ready <= 1'b0;
            end
        end
    end

    // One request. Idle gaps only come between bursts; valid stays high inside
    // a burst, so the next request is driven in the same step it is accepted.
    task automatic send_request(mode_t m, int id, int hi, int lg, int ticks);
        if (burst_left == 0)
        begin
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap_left > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap_left)
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        cmd.valid <= 1'b1;
        cmd.mode <= m;
        cmd.task_id <= TASK_W'(id);
        cmd.high_priority <= 1'(hi);
        cmd.long_quantum <= 1'(lg);
        cmd.sleep_ticks <= SLEEP_W'(ticks);
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    // Drain responses, then allow the longest pass to finish before a write.
    task automatic wait_idle();
        cmd.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (500)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= QUANT_W'(value);
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    task automatic set_regs(int t, int s, int l);
        write_reg(REG_TICK_MS, t);
        write_reg(REG_SHORT_US, s);
        write_reg(REG_LONG_US, l);
        cfg.valid <= 1'b0;
    endtask

    // Random request mix. Weighted toward passes and operations on live task
    // numbers so tasks cycle through ready, running, waiting and terminated.
    task automatic random_request(int max_sleep);
        int pick;
        int id;
        pick = $urandom_range(0, 99);
        id = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(1, 24);
        if (pick < 12)
            send_request(MODE_ADD, $urandom_range(0, 63), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom);
        else if (pick < 18)
            send_request(MODE_REMOVE, id, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
        else if (pick < 30)
            send_request(MODE_WAKE, id, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
        else if (pick < 48)
            send_request(MODE_SUSPEND, $urandom_range(0, 63), $urandom_range(0, 1),
                         $urandom_range(0, 1),
                         $urandom_range(0, 19) == 0 ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, max_sleep));
        else if (pick < 62)
            send_request(MODE_EXPIRE, $urandom_range(0, 63), 0, 0, $urandom);
        else if (pick < 72)
            send_request(MODE_FINISH, $urandom_range(0, 63), 1, 1, $urandom);
        else if (pick < 84)
            send_request(MODE_IDLE, $urandom_range(0, 63), 0, 1, $urandom);
        else
            send_request(MODE_QUERY, id, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad numbers before any add, then adds of each class,
        // sleep of zero and maximum ticks, wake of waiting and not waiting.
        send_request(MODE_QUERY, 0, 0, 0, 0);
        send_request(MODE_REMOVE, 63, 1, 1, 16'hFFFF);
        send_request(MODE_WAKE, 1, 0, 0, 0);
        send_request(MODE_SUSPEND, 0, 0, 0, 5);
        send_request(MODE_EXPIRE, 0, 0, 0, 0);
        send_request(MODE_ADD, 0, 1, 1, 0);
        send_request(MODE_ADD, 63, 0, 0, 16'hFFFF);
        send_request(MODE_ADD, 5, 1, 0, 0);
        send_request(MODE_ADD, 5, 0, 1, 0);
        send_request(MODE_IDLE, 0, 0, 0, 0);
        send_request(MODE_SUSPEND, 0, 0, 0, 0);
        send_request(MODE_SUSPEND, 0, 0, 0, 16'hFFFF);
        send_request(MODE_QUERY, 2, 0, 0, 0);
        send_request(MODE_WAKE, 3, 0, 0, 0);
        send_request(MODE_WAKE, 1, 0, 0, 0);
        send_request(MODE_EXPIRE, 0, 0, 0, 0);
        send_request(MODE_FINISH, 0, 0, 0, 0);
        send_request(MODE_REMOVE, 4, 0, 0, 0);
        send_request(MODE_REMOVE, 4, 0, 0, 0);
        send_request(MODE_QUERY, 4, 0, 0, 0);
        send_request(MODE_QUERY, 1, 0, 0, 0);
        send_request(MODE_IDLE, 0, 0, 0, 0);

        // Phases with different registers, extremes included.
        wait_idle();
        set_regs(255, 1, 1000000);
        repeat (220)
            random_request(6);
        wait_idle();
        set_regs(1, 1000000, 1);
        repeat (220)
            random_request(3);
        wait_idle();
        set_regs(200, 12345, 777);
        // fill the table to show the full status, then saturate waits
        repeat (70)
            send_request(MODE_ADD, 0, $urandom_range(0, 1), $urandom_range(0, 1), 0);
        repeat (240)
            random_request(10);
        wait_idle();
        set_regs(10, 10000, 20000);
        repeat (150)
            random_request(4);

        wait_idle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
